FILE: hdl/assert_macros.svh
// Assertion helpers shared by the RTL. Clock is clk_i, reset is rst_ni.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define ILE_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ile assertion failed");

// Checked at every edge, reset included.
`define ILE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("ile assertion failed");

`endif

FILE: hdl/ile_pkg.sv
`timescale 1ns / 1ps

package ile_pkg;

  localparam logic [2:0] CMD_APPEND = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_GET    = 3'd2;
  localparam logic [2:0] CMD_GET_OR = 3'd3;
  localparam logic [2:0] CMD_REMOVE = 3'd4;
  localparam logic [2:0] CMD_POP    = 3'd5;
  localparam logic [2:0] CMD_POP_OR = 3'd6;

  localparam int unsigned POS_W   = 4;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 5;

  typedef enum logic [2:0] {
    OP_APPEND,
    OP_INSERT,
    OP_GET,
    OP_GET_OR,
    OP_REMOVE,
    OP_POP,
    OP_POP_OR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    op_e               op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] word;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [WORD_W-1:0]  word;
    logic [COUNT_W-1:0] count;
  } rsp_t;

endpackage

FILE: hdl/indexed_list_engine_top.sv
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit words, CAPACITY entries deep. Each
// request on the slave side (cmd in tuser, position and operand in tdata)
// gives one response on the master side carrying a status in tuser and the
// read word and the entry count after the command in tdata. A decoder feeds
// a two-entry queue, and the list itself is a row of register cells that all
// shift in the same cycle, so one request is carried out per clock cycle at
// steady state while the master side takes responses; a request passes the
// queue and then the response register. While a response waits, the queue
// takes up to two more requests before the slave side stalls. Entry contents
// are not reset; the count resets to zero. The count on the output is the low 5 bits of the entry count.
module indexed_list_engine_top
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,  // position[3:0], operand_word[35:4], zero fill
  input  logic [2:0]  s_axis_tuser_i,  // cmd[2:0]
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,  // read_word[31:0], count[36:32], zero fill
  output logic [1:0]  m_axis_tuser_o   // status[1:0]
);

  req_t dec_req, q_req;
  logic q_valid, q_ready;
  rsp_t rsp;

  ile_front u_front (
    .cmd_i  (s_axis_tuser_i),
    .pos_i  (s_axis_tdata_i[3:0]),
    .word_i (s_axis_tdata_i[35:4]),
    .req_o  (dec_req)
  );

  ile_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_req_i    (dec_req),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_req_o   (q_req)
  );

  ile_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_ready_o (q_ready),
    .req_i       (q_req),
    .rsp_valid_o (m_axis_tvalid_o),
    .rsp_ready_i (m_axis_tready_i),
    .rsp_o       (rsp)
  );

  assign m_axis_tdata_o = {3'b000, rsp.count, rsp.word};
  assign m_axis_tuser_o = rsp.status;

endmodule

FILE: hdl/ile_front.sv
`timescale 1ns / 1ps

module ile_front
  import ile_pkg::*;
(
  input  logic [2:0]        cmd_i,
  input  logic [POS_W-1:0]  pos_i,
  input  logic [WORD_W-1:0] word_i,
  output req_t              req_o
);

  op_e op;

  always_comb begin
    case (cmd_i)
      CMD_APPEND: op = OP_APPEND;
      CMD_INSERT: op = OP_INSERT;
      CMD_GET:    op = OP_GET;
      CMD_GET_OR: op = OP_GET_OR;
      CMD_REMOVE: op = OP_REMOVE;
      CMD_POP:    op = OP_POP;
      CMD_POP_OR: op = OP_POP_OR;
      default:    op = OP_NOP;
    endcase
  end

  assign req_o.op   = op;
  assign req_o.pos  = pos_i;
  assign req_o.word = word_i;

endmodule

FILE: hdl/ile_fifo.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ile_fifo
  import ile_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output req_t out_req_o
);

  req_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_req_o   = slot_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= in_req_i;
    end
  end

  `ILE_ASSERT(a_fifo_cnt_bound, cnt_q != 2'd3)
  `ILE_ASSERT(a_fifo_ptr_gap, (cnt_q == 2'd1) |-> (wr_ptr_q != rd_ptr_q))

endmodule

FILE: hdl/ile_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ile_back
  import ile_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);

  localparam int unsigned FW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = (FW > POS_W) ? FW : POS_W;

  logic [WORD_W-1:0] entries_q [CAPACITY];
  logic [FW-1:0]     fill_q, fill_d;
  logic              rsp_valid_q;
  rsp_t              rsp_q, rsp_d;

  logic              take;
  logic [CW-1:0]     pos_c, fill_c;
  logic              empty, full;
  logic [WORD_W-1:0] rd_word, last_word;
  logic              do_append, do_insert, do_remove;

  assign take        = req_valid_i && (!rsp_valid_q || rsp_ready_i);
  assign req_ready_o = !rsp_valid_q || rsp_ready_i;
  assign pos_c       = CW'(req_i.pos);
  assign fill_c      = CW'(fill_q);
  assign empty       = (fill_q == '0);
  assign full        = (fill_q == FW'(CAPACITY));

  // read ports: by position and at the tail
  always_comb begin
    rd_word   = '0;
    last_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      if (CW'(k) == pos_c) begin
        rd_word = entries_q[k];
      end
      if (CW'(k) == fill_c - CW'(1)) begin
        last_word = entries_q[k];
      end
    end
  end

  always_comb begin
    rsp_d.status = ST_OK;
    rsp_d.word   = '0;
    fill_d       = fill_q;
    do_append    = 1'b0;
    do_insert    = 1'b0;
    do_remove    = 1'b0;
    case (req_i.op)
      OP_APPEND: begin
        if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          do_append = 1'b1;
          fill_d    = fill_q + FW'(1);
        end
      end
      OP_INSERT: begin
        if (pos_c > fill_c) begin
          rsp_d.status = ST_RANGE;
        end else if (full) begin
          rsp_d.status = ST_FULL;
        end else begin
          do_insert = 1'b1;
          fill_d    = fill_q + FW'(1);
        end
      end
      OP_GET: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (pos_c >= fill_c) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.word = rd_word;
        end
      end
      OP_GET_OR: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (pos_c >= fill_c) begin
          rsp_d.word = req_i.word;
        end else begin
          rsp_d.word = rd_word;
        end
      end
      OP_REMOVE: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else if (pos_c >= fill_c) begin
          rsp_d.status = ST_RANGE;
        end else begin
          rsp_d.word = rd_word;
          do_remove  = 1'b1;
          fill_d     = fill_q - FW'(1);
        end
      end
      OP_POP: begin
        if (empty) begin
          rsp_d.status = ST_EMPTY;
        end else begin
          rsp_d.word = last_word;
          fill_d     = fill_q - FW'(1);
        end
      end
      OP_POP_OR: begin
        if (empty) begin
          rsp_d.word = req_i.word;
        end else begin
          rsp_d.word = last_word;
          fill_d     = fill_q - FW'(1);
        end
      end
      default: begin
      end
    endcase
    rsp_d.count = COUNT_W'(fill_d);
  end

  // row of cells; each takes its neighbor on insert or remove, or the new word on append or insert
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [WORD_W-1:0] below, above, cell_d;
    logic [CW-1:0]     kc;

    assign kc = CW'(k);

    if (k == 0) begin : g_first
      assign below = req_i.word;
    end else begin : g_mid_lo
      assign below = entries_q[k-1];
    end

    if (k == CAPACITY - 1) begin : g_last
      assign above = entries_q[k];
    end else begin : g_mid_hi
      assign above = entries_q[k+1];
    end

    always_comb begin
      cell_d = entries_q[k];
      if (do_append && kc == fill_c) begin
        cell_d = req_i.word;
      end
      if (do_insert) begin
        if (kc == pos_c) begin
          cell_d = req_i.word;
        end else if (kc > pos_c && kc <= fill_c) begin
          cell_d = below;
        end
      end
      if (do_remove && kc >= pos_c && (kc + CW'(1)) < fill_c) begin
        cell_d = above;
      end
    end

    always_ff @(posedge clk_i) begin
      if (take) begin
        entries_q[k] <= cell_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (take) begin
        fill_q <= fill_d;
      end
      if (take) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  `ILE_ASSERT(a_fill_bound, fill_q <= FW'(CAPACITY))
  `ILE_ASSERT(a_append_grows,
    (take && req_i.op == OP_APPEND && !full) |=> (fill_q == $past(fill_q) + FW'(1)))
  `ILE_ASSERT(a_count_tracks, (take) |=> (rsp_q.count == COUNT_W'(fill_q)))

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import ile_pkg::*;

  localparam int unsigned CAPACITY = 16;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES = 80;

  typedef enum int unsigned {
    MIX_GROW,
    MIX_SHRINK,
    MIX_ANY
  } mix_e;

  // Shadow copy of the list; predicts each response and checks it in order.
  class list_shadow;
    logic [WORD_W-1:0] cells [CAPACITY];
    int unsigned used;
    rsp_t pending_rsp [$];
    int unsigned mismatches;

    function new();
      used = 0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      mismatches++;
    endtask

    task note_cmd(op_e op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] arg);
      rsp_t want;
      int unsigned idx;
      int unsigned i;
      want.status = ST_OK;
      want.word = '0;
      idx = pos;
      case (op)
        OP_APPEND: begin
          if (used >= CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            cells[used] = arg;
            used++;
          end
        end
        OP_INSERT: begin
          if (idx > used) begin
            want.status = ST_RANGE;
          end else if (used >= CAPACITY) begin
            want.status = ST_FULL;
          end else begin
            for (i = used; i > idx; i--) cells[i] = cells[i-1];
            cells[idx] = arg;
            used++;
          end
        end
        OP_GET: begin
          if (used == 0) want.status = ST_EMPTY;
          else if (idx >= used) want.status = ST_RANGE;
          else want.word = cells[idx];
        end
        OP_GET_OR: begin
          if (used == 0) want.status = ST_EMPTY;
          else if (idx >= used) want.word = arg;
          else want.word = cells[idx];
        end
        OP_REMOVE: begin
          if (used == 0) begin
            want.status = ST_EMPTY;
          end else if (idx >= used) begin
            want.status = ST_RANGE;
          end else begin
            want.word = cells[idx];
            for (i = idx; i + 1 < used; i++) cells[i] = cells[i+1];
            used--;
          end
        end
        OP_POP: begin
          if (used == 0) begin
            want.status = ST_EMPTY;
          end else begin
            used--;
            want.word = cells[used];
          end
        end
        OP_POP_OR: begin
          if (used == 0) begin
            want.word = arg;
          end else begin
            used--;
            want.word = cells[used];
          end
        end
        default: ;
      endcase
      want.count = COUNT_W'(used);
      pending_rsp.push_back(want);
    endtask

    task check_rsp(status_e st, logic [WORD_W-1:0] word, logic [COUNT_W-1:0] count);
      rsp_t want;
      if (pending_rsp.size() == 0) begin
        report($sformatf("unexpected response: status %0d word %h count %0d",
                         st, word, count));
      end else begin
        want = pending_rsp.pop_front();
        if (st !== want.status)
          report($sformatf("status %0d, expected %0d", st, want.status));
        if (word !== want.word)
          report($sformatf("read word %h, expected %h", word, want.word));
        if (count !== want.count)
          report($sformatf("count %0d, expected %0d", count, want.count));
      end
    endtask

    function int unsigned outstanding();
      return pending_rsp.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic s_valid = 1'b0;
  logic s_ready;
  logic [39:0] s_data = '0;
  logic [2:0] s_user = '0;
  logic m_valid;
  logic m_ready = 1'b0;
  logic [39:0] m_data;
  logic [1:0] m_user;

  bit tx_gaps = 1'b1;
  bit rx_gaps = 1'b1;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;

  list_shadow shadow;

  indexed_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (s_valid && s_ready)
      shadow.note_cmd(op_e'(s_user), s_data[3:0], s_data[35:4]);
    if (m_valid && m_ready)
      shadow.check_rsp(status_e'(m_user), m_data[31:0], m_data[36:32]);
  end

  // Response side: random back-pressure, or a long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        m_ready <= rx_gaps ? ($urandom_range(0, 99) >= 21) : 1'b1;
      end
    end
  end

  task automatic send_cmd(op_e op, logic [POS_W-1:0] pos, logic [WORD_W-1:0] arg);
    while (tx_gaps && $urandom_range(0, 99) < 21) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user <= op;
    s_data <= {4'b0, arg, pos};
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  task automatic run_mix(mix_e mode, int unsigned n);
    int unsigned cut [7];
    int unsigned done;
    int unsigned r;
    int unsigned k;
    int unsigned top;
    op_e op;
    logic [POS_W-1:0] pos;
    logic [WORD_W-1:0] arg;
    case (mode)
      MIX_GROW:   cut = '{45, 70, 78, 84, 90, 94, 98};
      MIX_SHRINK: cut = '{10, 20, 28, 35, 65, 82, 98};
      default:    cut = '{18, 36, 50, 62, 78, 88, 98};
    endcase
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      k = 0;
      while (k < 7 && r >= cut[k]) k++;
      op = op_e'(k);
      top = (shadow.used > 15) ? 15 : shadow.used;
      if ($urandom_range(0, 99) < 80) pos = POS_W'($urandom_range(0, top));
      else pos = POS_W'($urandom_range(0, 15));
      case ($urandom_range(0, 19))
        0: arg = 32'h8000_0000;
        1: arg = 32'h7fff_ffff;
        2: arg = 32'h0000_0000;
        3: arg = 32'hffff_ffff;
        default: arg = $urandom;
      endcase
      send_cmd(op, pos, arg);
      if (op != OP_NOP) done++;
    end
  endtask

  initial begin
    shadow = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list
    send_cmd(OP_POP, 4'd0, 32'h0);
    send_cmd(OP_POP_OR, 4'd0, 32'h8000_0000);
    send_cmd(OP_GET, 4'd15, 32'h0);
    send_cmd(OP_GET_OR, 4'd0, 32'hffff_ffff);
    send_cmd(OP_REMOVE, 4'd0, 32'h0);
    send_cmd(OP_INSERT, 4'd1, 32'h5555_5555);
    // insert at the end, then reads in and past range
    send_cmd(OP_INSERT, 4'd0, 32'h7fff_ffff);
    send_cmd(OP_APPEND, 4'd15, 32'hffff_ffff);
    send_cmd(OP_GET, 4'd1, 32'h0);
    send_cmd(OP_GET_OR, 4'd15, 32'h1234_5678);
    send_cmd(OP_GET, 4'd2, 32'h0);
    send_cmd(OP_REMOVE, 4'd9, 32'h0);
    send_cmd(OP_NOP, 4'd3, 32'hdead_beef);
    // fill to capacity
    for (int i = 0; i < CAPACITY - 2; i++)
      send_cmd(OP_APPEND, 4'd0, 32'h1000_0000 + i);
    send_cmd(OP_APPEND, 4'd0, 32'haaaa_aaaa);
    send_cmd(OP_INSERT, 4'd15, 32'haaaa_aaaa);
    send_cmd(OP_GET, 4'd15, 32'h0);
    send_cmd(OP_REMOVE, 4'd0, 32'h0);
    send_cmd(OP_POP, 4'd0, 32'h0);
    send_cmd(OP_POP_OR, 4'd0, 32'h0);

    for (int b = 0; b < 13; b++) begin
      tx_gaps = (b != 4);
      rx_gaps = (b != 4);
      if (b == 6) begin
        tx_gaps = 1'b0;
        hold_req = 1'b1;
        run_mix(MIX_ANY, 20);
        tx_gaps = 1'b1;
      end
      if (b == 9) begin
        s_valid <= 1'b0;
        while (shadow.outstanding() != 0) @(posedge clk);
      end
      case (b % 3)
        0: run_mix(MIX_GROW, 100);
        1: run_mix(MIX_SHRINK, 100);
        default: run_mix(MIX_ANY, 100);
      endcase
    end
    s_valid <= 1'b0;

    while (shadow.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (shadow.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
